>>> src/tssc_pkg.sv
// Shared constants and types for the two-list store and combine block.
package tssc_pkg;

    // List sizing
    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int MODE_W = 2;
    localparam logic [APB_AW-3:0] REG_IDX_MODE = '0;

    // Combine modes
    localparam logic [MODE_W-1:0] MODE_UNION     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd2;

    // Request codes
    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_SEARCH  = 2'd2,
        REQ_COMBINE = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_COMBINE   = 3'd6
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_R_RD,
        S_R_OUT,
        S_S_RD,
        S_S_CMP,
        S_C_OUTER,
        S_C_OLAT,
        S_C_INNER,
        S_C_ICMP,
        S_C_PUSH,
        S_C_FIN
    } state_t;

endpackage

>>> src/tssc_in_if.sv
// Request channel: valid/ready handshake carrying one request item.
interface tssc_in_if;
    logic                              valid;
    logic                              ready;
    tssc_pkg::req_t                    req_type;
    logic                              which_set;
    logic signed [tssc_pkg::ELEM_W-1:0] element_value;

    modport source (output valid, output req_type, output which_set,
                    output element_value, input ready);
    modport sink   (input valid, input req_type, input which_set,
                    input element_value, output ready);
endinterface

>>> src/tssc_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface tssc_out_if;
    logic                               valid;
    logic                               ready;
    tssc_pkg::status_t                  status;
    logic signed [tssc_pkg::ELEM_W-1:0] result_value;
    logic [tssc_pkg::CNT_W-1:0]         position;
    logic [tssc_pkg::CNT_W-1:0]         list_count;
    logic                               has_element;
    logic                               last_item;

    modport source (output valid, output status, output result_value, output position,
                    output list_count, output has_element, output last_item,
                    input ready);
    modport sink   (input valid, input status, input result_value, input position,
                    input list_count, input has_element, input last_item,
                    output ready);
endinterface

>>> src/tssc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tssc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> src/two_set_store_combine_core.sv
// Add, and remove of an empty list: result registered directly on accept; remove: S_R_RD, S_R_OUT.
// Search: each entry is read (S_S_RD) then compared (S_S_CMP) up to the hit or the list end.
// Combine: per outer entry S_C_OUTER and S_C_OLAT, then S_C_INNER and S_C_ICMP per inner entry
// compared, S_C_PUSH if emitted, then S_C_FIN; one comparator walks both list RAMs.
// One item at a time: ready only when idle with the output register empty; results can stall.
// Reset clears counts, combine_mode and control state; list RAMs hold garbage until written.
module two_set_store_combine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    tssc_in_if.sink                       in_ch,
    tssc_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tssc_pkg::APB_AW-1:0]   paddr,
    input  logic [tssc_pkg::APB_DW-1:0]   pwdata,
    output logic [tssc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CW = tssc_pkg::CNT_W;
    localparam int EW = tssc_pkg::ELEM_W;
    localparam int IW = tssc_pkg::IDX_W;

    tssc_pkg::state_t state_reg, state_next;

    logic [tssc_pkg::MODE_W-1:0] mode_reg;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] oi_reg, oi_next;
    logic [CW-1:0] ii_reg, ii_next;
    logic [CW-1:0] inner_len_reg, inner_len_next;
    logic          sel_reg, sel_next;
    logic          outer_b_reg, outer_b_next;
    logic          want_reg, want_next;
    logic          phase2_reg, phase2_next;
    logic          hit_reg, hit_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [EW-1:0] key_reg, key_next;
    logic [EW-1:0] cand_reg, cand_next;
    logic [EW-1:0] pend_reg, pend_next;

    // Output register
    logic              out_valid_reg;
    tssc_pkg::status_t out_status_reg;
    logic [EW-1:0]     out_value_reg;
    logic [CW-1:0]     out_pos_reg;
    logic [CW-1:0]     out_count_reg;
    logic              out_has_reg;
    logic              out_last_reg;

    // Output load request
    logic              out_load;
    tssc_pkg::status_t ld_status;
    logic [EW-1:0]     ld_value;
    logic [CW-1:0]     ld_pos;
    logic [CW-1:0]     ld_count;
    logic              ld_has;
    logic              ld_last;

    logic          accept;
    logic          out_free;
    logic [CW-1:0] in_cnt;
    logic [CW-1:0] sel_cnt;
    logic [CW-1:0] outer_len;
    logic          we_a, we_b;
    logic [IW-1:0] raddr_a, raddr_b;
    logic [EW-1:0] q_a, q_b;
    logic [EW-1:0] outer_q, inner_q;
    logic [EW-1:0] cmp_x, cmp_y;
    logic          cmp_eq;
    logic          cfg_hit;

    // Configuration register
    assign cfg_hit = (paddr[tssc_pkg::APB_AW-1:2] == tssc_pkg::REG_IDX_MODE);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {{(tssc_pkg::APB_DW - tssc_pkg::MODE_W){1'b0}}, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tssc_pkg::MODE_UNION;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            mode_reg <= pwdata[tssc_pkg::MODE_W-1:0];
        end
    end

    // Handshake
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == tssc_pkg::S_IDLE) && !out_valid_reg;
    assign accept       = in_ch.valid && in_ch.ready;
    assign in_cnt       = in_ch.which_set ? cnt_b_reg : cnt_a_reg;
    assign sel_cnt      = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign outer_len    = outer_b_reg ? cnt_b_reg : cnt_a_reg;

    // List RAMs: append writes at the count, reads walk outer or inner index
    assign we_a = accept && (in_ch.req_type == tssc_pkg::REQ_ADD) && !in_ch.which_set
                  && (cnt_a_reg != CW'(tssc_pkg::CAPACITY));
    assign we_b = accept && (in_ch.req_type == tssc_pkg::REQ_ADD) && in_ch.which_set
                  && (cnt_b_reg != CW'(tssc_pkg::CAPACITY));
    assign raddr_a = outer_b_reg ? ii_reg[IW-1:0] : oi_reg[IW-1:0];
    assign raddr_b = outer_b_reg ? oi_reg[IW-1:0] : ii_reg[IW-1:0];

    tssc_ram #(.WIDTH(EW), .DEPTH(tssc_pkg::CAPACITY)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[IW-1:0]),
        .wdata (in_ch.element_value),
        .raddr (raddr_a),
        .rdata (q_a)
    );

    tssc_ram #(.WIDTH(EW), .DEPTH(tssc_pkg::CAPACITY)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[IW-1:0]),
        .wdata (in_ch.element_value),
        .raddr (raddr_b),
        .rdata (q_b)
    );

    assign outer_q = outer_b_reg ? q_b : q_a;
    assign inner_q = outer_b_reg ? q_a : q_b;

    // Shared comparator: search key against outer entry, or candidate against inner entry
    assign cmp_x  = (state_reg == tssc_pkg::S_S_CMP) ? outer_q : inner_q;
    assign cmp_y  = (state_reg == tssc_pkg::S_S_CMP) ? key_reg : cand_reg;
    assign cmp_eq = (cmp_x == cmp_y);

    // Control and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tssc_pkg::S_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            oi_reg         <= '0;
            ii_reg         <= '0;
            inner_len_reg  <= '0;
            sel_reg        <= 1'b0;
            outer_b_reg    <= 1'b0;
            want_reg       <= 1'b0;
            phase2_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            oi_reg         <= oi_next;
            ii_reg         <= ii_next;
            inner_len_reg  <= inner_len_next;
            sel_reg        <= sel_next;
            outer_b_reg    <= outer_b_next;
            want_reg       <= want_next;
            phase2_reg     <= phase2_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        cand_reg <= cand_next;
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_value_reg  <= ld_value;
            out_pos_reg    <= ld_pos;
            out_count_reg  <= ld_count;
            out_has_reg    <= ld_has;
            out_last_reg   <= ld_last;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        oi_next         = oi_reg;
        ii_next         = ii_reg;
        inner_len_next  = inner_len_reg;
        sel_next        = sel_reg;
        outer_b_next    = outer_b_reg;
        want_next       = want_reg;
        phase2_next     = phase2_reg;
        hit_next        = hit_reg;
        pend_valid_next = pend_valid_reg;
        key_next        = key_reg;
        cand_next       = cand_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        ld_status       = tssc_pkg::ST_ADDED;
        ld_value        = '0;
        ld_pos          = '0;
        ld_count        = sel_cnt;
        ld_has          = 1'b0;
        ld_last         = 1'b1;

        case (state_reg)
            tssc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    sel_next     = in_ch.which_set;
                    key_next     = in_ch.element_value;
                    outer_b_next = in_ch.which_set;
                    oi_next      = '0;
                    ld_count     = in_cnt;
                    case (in_ch.req_type)
                        tssc_pkg::REQ_ADD:
                        begin
                            out_load = 1'b1;
                            if (in_cnt == CW'(tssc_pkg::CAPACITY))
                            begin
                                ld_status = tssc_pkg::ST_FULL;
                            end
                            else
                            begin
                                ld_status = tssc_pkg::ST_ADDED;
                                ld_count  = in_cnt + CW'(1);
                                if (in_ch.which_set)
                                begin
                                    cnt_b_next = in_cnt + CW'(1);
                                end
                                else
                                begin
                                    cnt_a_next = in_cnt + CW'(1);
                                end
                            end
                        end
                        tssc_pkg::REQ_REMOVE:
                        begin
                            if (in_cnt == '0)
                            begin
                                out_load  = 1'b1;
                                ld_status = tssc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                oi_next    = in_cnt - CW'(1);
                                state_next = tssc_pkg::S_R_RD;
                                if (in_ch.which_set)
                                begin
                                    cnt_b_next = in_cnt - CW'(1);
                                end
                                else
                                begin
                                    cnt_a_next = in_cnt - CW'(1);
                                end
                            end
                        end
                        tssc_pkg::REQ_SEARCH:
                        begin
                            state_next = tssc_pkg::S_S_RD;
                        end
                        tssc_pkg::REQ_COMBINE:
                        begin
                            pend_valid_next = 1'b0;
                            outer_b_next    = 1'b0;
                            case (mode_reg)
                                tssc_pkg::MODE_UNION:
                                begin
                                    // first pass emits all of A, then B against A
                                    inner_len_next = '0;
                                    want_next      = 1'b0;
                                    phase2_next    = 1'b1;
                                    state_next     = tssc_pkg::S_C_OUTER;
                                end
                                tssc_pkg::MODE_INTERSECT:
                                begin
                                    inner_len_next = cnt_b_reg;
                                    want_next      = 1'b1;
                                    phase2_next    = 1'b0;
                                    state_next     = tssc_pkg::S_C_OUTER;
                                end
                                tssc_pkg::MODE_DIFF:
                                begin
                                    inner_len_next = cnt_b_reg;
                                    want_next      = 1'b0;
                                    phase2_next    = 1'b0;
                                    state_next     = tssc_pkg::S_C_OUTER;
                                end
                                default:
                                begin
                                    state_next = tssc_pkg::S_C_FIN;
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = tssc_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // Remove: RAM read of the popped entry
            tssc_pkg::S_R_RD:
            begin
                state_next = tssc_pkg::S_R_OUT;
            end

            tssc_pkg::S_R_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_status  = tssc_pkg::ST_REMOVED;
                    ld_value   = outer_q;
                    state_next = tssc_pkg::S_IDLE;
                end
            end

            // Search: walk the list with the comparator
            tssc_pkg::S_S_RD:
            begin
                if (oi_reg == outer_len)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_status  = tssc_pkg::ST_NOT_FOUND;
                        state_next = tssc_pkg::S_IDLE;
                    end
                end
                else
                begin
                    state_next = tssc_pkg::S_S_CMP;
                end
            end

            tssc_pkg::S_S_CMP:
            begin
                if (cmp_eq)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_status  = tssc_pkg::ST_FOUND;
                        ld_pos     = oi_reg + CW'(1);
                        state_next = tssc_pkg::S_IDLE;
                    end
                end
                else
                begin
                    oi_next    = oi_reg + CW'(1);
                    state_next = tssc_pkg::S_S_RD;
                end
            end

            // Combine: outer loop over candidates
            tssc_pkg::S_C_OUTER:
            begin
                if (oi_reg == outer_len)
                begin
                    if (phase2_reg)
                    begin
                        phase2_next    = 1'b0;
                        outer_b_next   = 1'b1;
                        inner_len_next = cnt_a_reg;
                        oi_next        = '0;
                    end
                    else
                    begin
                        state_next = tssc_pkg::S_C_FIN;
                    end
                end
                else
                begin
                    state_next = tssc_pkg::S_C_OLAT;
                end
            end

            tssc_pkg::S_C_OLAT:
            begin
                cand_next  = outer_q;
                ii_next    = '0;
                hit_next   = 1'b0;
                state_next = tssc_pkg::S_C_INNER;
            end

            // Inner membership scan, stops at the first hit
            tssc_pkg::S_C_INNER:
            begin
                if (hit_reg || (ii_reg == inner_len_reg))
                begin
                    if (hit_reg == want_reg)
                    begin
                        state_next = tssc_pkg::S_C_PUSH;
                    end
                    else
                    begin
                        oi_next    = oi_reg + CW'(1);
                        state_next = tssc_pkg::S_C_OUTER;
                    end
                end
                else
                begin
                    state_next = tssc_pkg::S_C_ICMP;
                end
            end

            tssc_pkg::S_C_ICMP:
            begin
                hit_next   = cmp_eq;
                ii_next    = ii_reg + CW'(1);
                state_next = tssc_pkg::S_C_INNER;
            end

            // Hold one element back so the final one can carry last_item
            tssc_pkg::S_C_PUSH:
            begin
                if (!pend_valid_reg)
                begin
                    pend_next       = cand_reg;
                    pend_valid_next = 1'b1;
                    oi_next         = oi_reg + CW'(1);
                    state_next      = tssc_pkg::S_C_OUTER;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_status  = tssc_pkg::ST_COMBINE;
                    ld_value   = pend_reg;
                    ld_has     = 1'b1;
                    ld_last    = 1'b0;
                    pend_next  = cand_reg;
                    oi_next    = oi_reg + CW'(1);
                    state_next = tssc_pkg::S_C_OUTER;
                end
            end

            tssc_pkg::S_C_FIN:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    ld_status       = tssc_pkg::ST_COMBINE;
                    ld_value        = pend_valid_reg ? pend_reg : '0;
                    ld_has          = pend_valid_reg;
                    pend_valid_next = 1'b0;
                    state_next      = tssc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tssc_pkg::S_IDLE;
            end
        endcase
    end

    // Result channel
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.position     = out_pos_reg;
    assign out_ch.list_count   = out_count_reg;
    assign out_ch.has_element  = out_has_reg;
    assign out_ch.last_item    = out_last_reg;

`ifndef SYNTH
    // Counts stay within capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CW'(tssc_pkg::CAPACITY)) && (cnt_b_reg <= CW'(tssc_pkg::CAPACITY)))
        else $error("list count above capacity");

    // An accepted add to a non-full list A grows it by one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.req_type == tssc_pkg::REQ_ADD) && !in_ch.which_set
        && (cnt_a_reg != CW'(tssc_pkg::CAPACITY))
        |=> cnt_a_reg == $past(cnt_a_reg) + CW'(1))
        else $error("add did not grow list A");

    // Single-result requests always mark their item last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.status != tssc_pkg::ST_COMBINE) |-> out_ch.last_item)
        else $error("non-combine item not marked last");

    // An empty combine is a lone, zero-valued item
    a_empty_combine: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.status == tssc_pkg::ST_COMBINE) && !out_ch.has_element
        |-> out_ch.last_item && (out_ch.result_value == '0))
        else $error("malformed empty combine item");
`endif

endmodule
